[rtl/core/bffa_pkg.sv]
// shared constants and controller/datapath interface types for the bitmap allocator
`default_nettype none

package bffa_pkg;

    localparam int DEF_ROWS = 16;
    localparam int DEF_COLS = 32;

    localparam int OP_W     = 1;
    localparam int IDX_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic alloc_commit;
        logic divide;
        logic split;
        logic free_commit;
        logic range_fail;
        logic out_load;
    } bffa_cmd_t;

    typedef struct packed {
        logic req_free;
        logic clr_last;
        logic scan_hit;
        logic scan_miss_last;
        logic in_range;
        logic out_free;
    } bffa_sts_t;

endpackage

`default_nettype wire

[rtl/core/bffa_ctrl.sv]
// sequencing state machine: clearing pass, row scan and free steps
`default_nettype none

module bffa_ctrl
    import bffa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire bffa_sts_t sts,
    output bffa_cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_FDIV   = 7'b0001000,
        S_FSPLIT = 7'b0010000,
        S_FCHECK = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.req_free ? S_FDIV : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan         = 1'b1;
                cmd.alloc_commit = 1'b1;
                if (sts.scan_hit || sts.scan_miss_last) begin
                    state_next = S_RESP;
                end
            end
            S_FDIV: begin
                if (sts.in_range) begin
                    cmd.divide = 1'b1;
                    state_next = S_FSPLIT;
                end else begin
                    cmd.range_fail = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_FSPLIT: begin
                cmd.split  = 1'b1;
                state_next = S_FCHECK;
            end
            S_FCHECK: begin
                cmd.free_commit = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/bffa_datapath.sv]
// bitmap memory, row scan pipeline, index split, free counter and result register
`default_nettype none

module bffa_datapath
    import bffa_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bffa_cmd_t           cmd,
    output bffa_sts_t                sts,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [IDX_W-1:0]    s_entry_index,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [IDX_W-1:0]         m_granted_index,
    output logic [COUNT_W-1:0]       m_free_count
);

    localparam int TOTAL  = ROWS * COLS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int SA_W   = $clog2(ROWS + 1);
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int COL_L  = $clog2(COLS);
    localparam int DIV_SH = IDX_W + COL_L;
    localparam int RECIP  = ((2 ** DIV_SH) + COLS - 1) / COLS;
    localparam int PW     = DIV_SH + IDX_W + 1;

    localparam logic [COLS-1:0] ONE_BIT = COLS'(1);

    logic [COLS-1:0] mem [ROWS];

    logic [ROW_W-1:0]    clr_addr_reg;
    logic [SA_W-1:0]     scan_addr_reg;
    logic [ROW_W-1:0]    chk_row_reg;
    logic                chk_valid_reg;
    logic [COLS-1:0]     rd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    q_reg;
    logic [COL_W-1:0]    col_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]    res_grant_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [IDX_W-1:0]    m_granted_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                scan_issue;
    logic                any_zero;
    logic [COL_W-1:0]    first_col;
    logic                hit;
    logic                bit_set;
    logic [WIDE_W-1:0]   grant_wide;
    logic [WIDE_W-1:0]   cnt_wide;
    logic [PW-1:0]       div_prod;
    logic [IDX_W-1:0]    rem;
    logic [ROW_W-1:0]    free_row;
    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [COLS-1:0]     wdata;
    logic [ROW_W-1:0]    raddr;
    logic                out_free;

    // lowest clear column of the row under check
    always_comb begin
        first_col = '0;
        for (int c = COLS - 1; c >= 0; c--) begin
            if (!rd_reg[c]) begin
                first_col = COL_W'(c);
            end
        end
    end

    assign any_zero   = ~&rd_reg;
    assign hit        = chk_valid_reg && any_zero;
    assign scan_issue = cmd.scan && (scan_addr_reg < SA_W'(ROWS));
    assign bit_set    = rd_reg[col_reg];
    assign grant_wide = WIDE_W'(chk_row_reg) * WIDE_W'(COLS) + WIDE_W'(first_col);
    assign cnt_wide   = WIDE_W'(cnt_reg);
    assign div_prod   = PW'(idx_reg) * PW'(RECIP);
    assign rem        = idx_reg - IDX_W'(q_reg * IDX_W'(COLS));
    assign free_row   = ROW_W'(q_reg);
    assign out_free   = !m_valid_reg || m_ready;

    assign sts.req_free       = (s_operation == OP_FREE);
    assign sts.clr_last       = (clr_addr_reg == ROW_W'(ROWS - 1));
    assign sts.scan_hit       = hit;
    assign sts.scan_miss_last = chk_valid_reg && !any_zero
                                && (chk_row_reg == ROW_W'(ROWS - 1));
    assign sts.in_range       = (WIDE_W'(idx_reg) < WIDE_W'(TOTAL));
    assign sts.out_free       = out_free;

    always_comb begin
        we    = 1'b0;
        waddr = chk_row_reg;
        wdata = rd_reg | (ONE_BIT << first_col);
        if (cmd.clear) begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end else if (cmd.alloc_commit && hit) begin
            we = 1'b1;
        end else if (cmd.free_commit && bit_set) begin
            we    = 1'b1;
            waddr = free_row;
            wdata = rd_reg & ~(ONE_BIT << col_reg);
        end
    end

    assign raddr = cmd.split ? free_row : scan_addr_reg[ROW_W-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            chk_valid_reg <= 1'b0;
            cnt_reg       <= CNT_W'(TOTAL);
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.load) begin
                scan_addr_reg <= '0;
                chk_valid_reg <= 1'b0;
            end else begin
                if (scan_issue) begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                chk_valid_reg <= scan_issue;
            end
            if (cmd.alloc_commit && hit) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else if (cmd.free_commit && bit_set) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_row_reg <= scan_addr_reg[ROW_W-1:0];
        if (cmd.load) begin
            idx_reg <= s_entry_index;
        end
        if (cmd.divide) begin
            q_reg <= div_prod[DIV_SH +: IDX_W];
        end
        if (cmd.split) begin
            col_reg <= rem[COL_W-1:0];
        end
        if (cmd.alloc_commit) begin
            if (hit) begin
                res_status_reg <= STATUS_OK;
                res_grant_reg  <= grant_wide[IDX_W-1:0];
            end else begin
                res_status_reg <= STATUS_FULL;
                res_grant_reg  <= '0;
            end
        end
        if (cmd.free_commit) begin
            res_status_reg <= bit_set ? STATUS_OK : STATUS_BAD_FREE;
            res_grant_reg  <= '0;
        end
        if (cmd.range_fail) begin
            res_status_reg <= STATUS_BAD_FREE;
            res_grant_reg  <= '0;
        end
        if (cmd.out_load) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_grant_reg;
            m_count_reg   <= cnt_wide[COUNT_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_granted_reg;
    assign m_free_count    = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(TOTAL))
        else $error("free count above total entries");

    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten while occupied");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != STATUS_OK) |-> (m_granted_reg == '0))
        else $error("nonzero index on a failed request");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit && sts.scan_miss_last |-> (cnt_reg == '0))
        else $error("bitmap full while free count nonzero");

endmodule

`default_nettype wire

[rtl/core/bitmap_first_free_allocator_core.sv]
// top level of the bitmap first-free entry allocator
//
// Allocates and frees entries of a BITMAP_ROWS x BITMAP_COLS used-bit bitmap held in
// a one-port-read memory, one row per word. After reset a clearing pass writes every
// row to zero while s_ready is low. An allocate transaction streams rows through the
// single read port, one row per cycle, and reports its result after it finds the row
// with the lowest free entry or has checked the last row of a full bitmap. A free
// transaction splits the index by reciprocal multiply, reads the row and updates it;
// an out-of-range index skips these steps. One transaction is worked on at a time; a
// new one is taken while the previous result still waits in the output register.
`default_nettype none

module bitmap_first_free_allocator_core
    import bffa_pkg::*;
#(
    parameter int BITMAP_ROWS = DEF_ROWS,
    parameter int BITMAP_COLS = DEF_COLS
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [IDX_W-1:0]    s_entry_index,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [IDX_W-1:0]         m_granted_index,
    output logic [COUNT_W-1:0]       m_free_count
);

    bffa_cmd_t cmd;
    bffa_sts_t sts;

    bffa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bffa_datapath #(
        .ROWS (BITMAP_ROWS),
        .COLS (BITMAP_COLS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_operation     (s_operation),
        .s_entry_index   (s_entry_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_free_count    (m_free_count)
    );

endmodule

`default_nettype wire
